// File: rtl/mlft_pkg.sv
// ============================================================================
// mlft_pkg: shared types and constants for the MPLS label forwarding table
// Request and response payloads, operation and status codes.
// ============================================================================
package mlft_pkg;

    localparam int unsigned LABEL_W         = 20;
    localparam int unsigned TABLE_DEPTH_DEF = 64;
    localparam int unsigned MAX_OPS_DEF     = 2;
    localparam int unsigned IF_WIDTH_DEF    = 8;
    localparam logic [LABEL_W-1:0] FIRST_LABEL = 20'd15;
    localparam logic [LABEL_W-1:0] LAST_LABEL  = 20'hFFFFF;

    localparam logic [1:0] OPER_RESOLVE = 2'd0;
    localparam logic [1:0] OPER_INSTALL = 2'd1;
    localparam logic [1:0] OPER_REMOVE  = 2'd2;
    localparam logic [1:0] OPER_BAD     = 2'd3;

    localparam logic [1:0] LOP_PUSH = 2'd0;
    localparam logic [1:0] LOP_SWAP = 2'd1;
    localparam logic [1:0] LOP_POP  = 2'd2;
    localparam logic [1:0] LOP_BAD  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MISS      = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_EXHAUSTED = 3'd3;
    localparam logic [2:0] ST_BAD       = 3'd4;

    typedef struct packed {
        logic [1:0]         operation;
        logic [LABEL_W-1:0] in_label;
        logic               allocate_new;
        logic               in_if_any;
        logic [7:0]         in_interface;
        logic [7:0]         out_interface;
        logic [1:0]         op_count;
        logic [1:0]         op0_code;
        logic [LABEL_W-1:0] op0_label;
        logic [1:0]         op1_code;
        logic [LABEL_W-1:0] op1_label;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [LABEL_W-1:0] label;
        logic [7:0]         found_out_interface;
        logic [1:0]         found_op_count;
        logic [1:0]         found_op0_code;
        logic [LABEL_W-1:0] found_op0_label;
        logic [1:0]         found_op1_code;
        logic [LABEL_W-1:0] found_op1_label;
    } resp_t;

    // Classified command handed from front to back.
    typedef enum logic [1:0] {
        CMD_RESOLVE,
        CMD_INSTALL,
        CMD_REMOVE,
        CMD_REJECT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        req_t       req;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_SHIFT,
        BK_RESP
    } bk_state_t;

endpackage

// File: rtl/mpls_label_forwarding_table.sv
// ============================================================================
// mpls_label_forwarding_table: ordered MPLS label table
// Resolve, install (allocate or update) and remove with in-order compaction.
// ============================================================================
// One request is handled at a time. The table sits in a memory with one write
// port and one read port that the back end walks one entry per cycle. An
// allocating install or a rejected request goes straight to its result;
// resolve, update and remove read from the first entry on until a hit or the
// last entry. A remove then moves each entry above the hit down by one to
// close the gap. A two-entry request queue takes further requests while one
// is worked on; the back end starts the next request only after the waiting
// result has been popped.
module mpls_label_forwarding_table #(
    parameter int unsigned TABLE_DEPTH = mlft_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned MAX_OPS     = mlft_pkg::MAX_OPS_DEF,
    parameter int unsigned IF_WIDTH    = mlft_pkg::IF_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  mlft_pkg::req_t  request,
    output logic            empty,
    input  logic            pop,
    output mlft_pkg::resp_t response
);
    import mlft_pkg::*;

    logic cmd_valid, cmd_take, rsp_valid;
    cmd_t cmd;

    mlft_front #(.MAX_OPS(MAX_OPS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .data(request),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
    );

    mlft_back #(.TABLE_DEPTH(TABLE_DEPTH), .IF_WIDTH(IF_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
        .cmd(cmd), .rsp_valid(rsp_valid), .rsp_take(pop), .rsp(response)
    );

    assign empty = !rsp_valid;

endmodule

// File: rtl/mlft_front.sv
// ============================================================================
// mlft_front: request intake and classification
// Accepts requests, normalizes operations, and queues commands for the back.
// ============================================================================
module mlft_front #(
    parameter int unsigned MAX_OPS = mlft_pkg::MAX_OPS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  mlft_pkg::req_t data,
    output logic          cmd_valid,
    input  logic          cmd_take,
    output mlft_pkg::cmd_t cmd
);
    import mlft_pkg::*;

    localparam int unsigned SLOTS = (MAX_OPS < 2) ? MAX_OPS : 2;

    cmd_t q_reg [2];
    logic wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t cls;
    logic [1:0] c;
    logic bad;

    always_comb
    begin
        cls.req = data;
        c = (data.op_count > 2'(SLOTS)) ? 2'(SLOTS) : data.op_count;
        cls.req.op_count = c;
        bad = 1'b0;
        if (c < 2'd1)
        begin
            cls.req.op0_code = LOP_PUSH;
            cls.req.op0_label = '0;
        end
        else if (data.op0_code == LOP_BAD)
            bad = 1'b1;
        else if (data.op0_code == LOP_POP)
            cls.req.op0_label = '0;
        if (c < 2'd2)
        begin
            cls.req.op1_code = LOP_PUSH;
            cls.req.op1_label = '0;
        end
        else if (data.op1_code == LOP_BAD)
            bad = 1'b1;
        else if (data.op1_code == LOP_POP)
            cls.req.op1_label = '0;
        if (data.in_if_any)
            cls.req.in_interface = '0;
        case (data.operation)
            OPER_RESOLVE: cls.kind = CMD_RESOLVE;
            OPER_REMOVE:  cls.kind = CMD_REMOVE;
            OPER_INSTALL: cls.kind = bad ? CMD_REJECT : CMD_INSTALL;
            default:      cls.kind = CMD_REJECT;
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push && !full)
        begin
            wp_next  = ~wp_reg;
            cnt_next = cnt_next + 2'd1;
        end
        if (cmd_take && cmd_valid)
        begin
            rp_next  = ~rp_reg;
            cnt_next = cnt_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            q_reg[wp_reg] <= cls;
    end

endmodule

// File: rtl/mlft_back.sv
// ============================================================================
// mlft_back: table engine
// Holds the entry memory; scans, installs, and compacts one entry a cycle.
// ============================================================================
module mlft_back #(
    parameter int unsigned TABLE_DEPTH = mlft_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned IF_WIDTH    = mlft_pkg::IF_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_take,
    input  mlft_pkg::cmd_t  cmd,
    output logic           rsp_valid,
    input  logic           rsp_take,
    output mlft_pkg::resp_t rsp
);
    import mlft_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    typedef struct packed {
        logic [LABEL_W-1:0]  lbl;
        logic                any;
        logic [IF_WIDTH-1:0] ifc;
        logic [IF_WIDTH-1:0] oif;
        logic [1:0]          cnt;
        logic [1:0]          c0;
        logic [LABEL_W-1:0]  l0;
        logic [1:0]          c1;
        logic [LABEL_W-1:0]  l1;
    } ent_t;

    ent_t mem [TABLE_DEPTH];
    ent_t rd_reg;

    bk_state_t st_reg, st_next;
    cmd_t   cur_reg, cur_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          rdv_reg, rdv_next;
    logic [LABEL_W-1:0] high_reg, high_next;
    resp_t  out_reg, out_next;
    logic   outv_reg, outv_next;
    logic   we;
    logic [AW-1:0] waddr, raddr;
    ent_t   wdata, newent;
    logic   lmatch, imatch;

    assign cmd_take  = (st_reg == BK_IDLE) && !outv_reg;
    assign rsp_valid = outv_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        newent.lbl = cur_reg.req.in_label;
        newent.any = cur_reg.req.in_if_any;
        newent.ifc = cur_reg.req.in_interface[IF_WIDTH-1:0];
        newent.oif = cur_reg.req.out_interface[IF_WIDTH-1:0];
        newent.cnt = cur_reg.req.op_count;
        newent.c0  = cur_reg.req.op0_code;
        newent.l0  = cur_reg.req.op0_label;
        newent.c1  = cur_reg.req.op1_code;
        newent.l1  = cur_reg.req.op1_label;
        lmatch = (rd_reg.lbl == cur_reg.req.in_label);
        imatch = cur_reg.req.in_if_any ||
                 (!rd_reg.any && rd_reg.ifc == cur_reg.req.in_interface[IF_WIDTH-1:0]);
    end

    // Next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            BK_IDLE:
                if (cmd_valid && cmd_take)
                begin
                    if (cmd.kind == CMD_REJECT)
                        st_next = BK_RESP;
                    else if (cmd.kind == CMD_INSTALL && cmd.req.allocate_new)
                        st_next = BK_RESP;
                    else
                        st_next = BK_SCAN;
                end
            BK_SCAN:
                if (!rdv_reg)
                begin
                    if (idx_reg >= count_reg)
                        st_next = BK_RESP;
                end
                else if (lmatch && (cur_reg.kind != CMD_RESOLVE || imatch))
                    st_next = (cur_reg.kind == CMD_REMOVE) ? BK_SHIFT : BK_RESP;
                else if (idx_reg >= count_reg)
                    st_next = BK_RESP;
            BK_SHIFT:
                if (idx_reg + CW'(1) >= count_reg)
                    st_next = BK_RESP;
            BK_RESP:
                st_next = BK_IDLE;
            default:
                st_next = BK_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cur_next   = cur_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        rdv_next   = 1'b0;
        high_next  = high_reg;
        out_next   = out_reg;
        outv_next  = outv_reg && !rsp_take;
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = newent;
        raddr = idx_reg[AW-1:0];
        case (st_reg)
            BK_IDLE:
                if (cmd_valid && cmd_take)
                begin
                    cur_next = cmd;
                    idx_next = '0;
                    out_next = '0;
                    out_next.label = cmd.req.in_label;
                    out_next.status = ST_MISS;
                    if (cmd.kind == CMD_REJECT)
                        out_next.status = ST_BAD;
                    else if (cmd.kind == CMD_INSTALL && cmd.req.allocate_new)
                    begin
                        if (count_reg >= CW'(TABLE_DEPTH))
                            out_next.status = ST_FULL;
                        else if (high_reg >= LAST_LABEL)
                            out_next.status = ST_EXHAUSTED;
                        else
                        begin
                            we = 1'b1;
                            waddr = count_reg[AW-1:0];
                            wdata.lbl = high_reg + 20'd1;
                            wdata.any = cmd.req.in_if_any;
                            wdata.ifc = cmd.req.in_interface[IF_WIDTH-1:0];
                            wdata.oif = cmd.req.out_interface[IF_WIDTH-1:0];
                            wdata.cnt = cmd.req.op_count;
                            wdata.c0  = cmd.req.op0_code;
                            wdata.l0  = cmd.req.op0_label;
                            wdata.c1  = cmd.req.op1_code;
                            wdata.l1  = cmd.req.op1_label;
                            high_next = high_reg + 20'd1;
                            count_next = count_reg + CW'(1);
                            out_next.status = ST_OK;
                            out_next.label = high_reg + 20'd1;
                        end
                    end
                end
            BK_SCAN:
                if (!rdv_reg)
                begin
                    if (idx_reg < count_reg)
                    begin
                        rdv_next = 1'b1;
                        raddr = idx_reg[AW-1:0];
                    end
                end
                else if (lmatch && (cur_reg.kind != CMD_RESOLVE || imatch))
                begin
                    out_next.status = ST_OK;
                    if (cur_reg.kind == CMD_RESOLVE)
                    begin
                        out_next.found_out_interface = 8'(rd_reg.oif);
                        out_next.found_op_count  = rd_reg.cnt;
                        out_next.found_op0_code  = rd_reg.c0;
                        out_next.found_op0_label = rd_reg.l0;
                        out_next.found_op1_code  = rd_reg.c1;
                        out_next.found_op1_label = rd_reg.l1;
                    end
                    else if (cur_reg.kind == CMD_INSTALL)
                    begin
                        we = 1'b1;
                        waddr = idx_reg[AW-1:0];
                    end
                    else
                    begin
                        // hold idx at the hole; prefetch the entry above it
                        raddr = AW'(idx_reg + CW'(1));
                        if (idx_reg + CW'(1) >= count_reg)
                            count_next = count_reg - CW'(1);
                    end
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    if (idx_reg + CW'(1) < count_reg)
                    begin
                        rdv_next = 1'b1;
                        raddr = AW'(idx_reg + CW'(1));
                    end
                end
            BK_SHIFT:
                if (idx_reg + CW'(1) < count_reg)
                begin
                    // move entry above down into the hole
                    we = 1'b1;
                    waddr = idx_reg[AW-1:0];
                    wdata = rd_reg;
                    idx_next = idx_reg + CW'(1);
                    raddr = AW'(idx_reg + CW'(2));
                    if (idx_reg + CW'(2) >= count_reg)
                        count_next = count_reg - CW'(1);
                end
            BK_RESP:
                outv_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= BK_IDLE;
            count_reg <= '0;
            high_reg  <= FIRST_LABEL;
            outv_reg  <= 1'b0;
            rdv_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            st_reg    <= st_next;
            count_reg <= count_next;
            high_reg  <= high_next;
            outv_reg  <= outv_next;
            rdv_reg   <= rdv_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

endmodule

// File: rtl/mlft_checker.sv
// ============================================================================
// mlft_checker: port-level checks for the label table
// Watches the queue handshakes and result codes on the top level.
// ============================================================================
module mlft_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            push,
    input logic            full,
    input logic            empty,
    input logic            pop,
    input mlft_pkg::resp_t response
);
    import mlft_pkg::*;

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> response.status <= ST_BAD)
        else $error("status out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(response)))
        else $error("result changed before transfer");

    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && response.status != ST_OK) |-> response.found_op_count == 2'd0)
        else $error("entry data on failed request");

    // The request queue only fills through an input transfer.
    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        (!full && !push) |=> !full)
        else $error("full without a request");

endmodule

bind mpls_label_forwarding_table mlft_checker u_mlft_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .empty(empty), .pop(pop), .response(response)
);

// File: verif/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking testbench for the MPLS label forwarding table
// Requests are pushed from a pending queue with random gaps. Responses are
// popped with random stalls and compared against a table predictor.
// ============================================================================
module tb;
    import mlft_pkg::*;

    localparam int DEPTH = 64;

    logic  clk;
    logic  rst_n;
    logic  push;
    logic  full;
    req_t  request;
    logic  empty;
    logic  pop;
    resp_t response;

    mpls_label_forwarding_table DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .request(request),
        .empty(empty), .pop(pop), .response(response)
    );

    // Predicted table contents.
    typedef struct packed {
        logic [LABEL_W-1:0] lbl;
        logic               any;
        logic [7:0]         iface;
        logic [7:0]         oif;
        logic [1:0]         cnt;
        logic [1:0]         c0;
        logic [LABEL_W-1:0] l0;
        logic [1:0]         c1;
        logic [LABEL_W-1:0] l1;
    } route_t;

    route_t             routes[DEPTH];
    int                 route_count = 0;
    logic [LABEL_W-1:0] last_label = FIRST_LABEL;

    req_t  pending_reqs[$];
    resp_t expected_resps[$];
    int    fail_count = 0;
    int    idle_pct;
    bit    hold_push;

    task automatic add_req(req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    function automatic int find_label(logic [LABEL_W-1:0] lbl);
        for (int i = 0; i < route_count; i++)
            if (routes[i].lbl == lbl)
                return i;
        return -1;
    endfunction

    function automatic resp_t apply_request(req_t r);
        resp_t  o;
        route_t e;
        int     idx;
        logic [1:0] cnt;
        o = '0;
        o.label = r.in_label;
        if (r.operation == OPER_RESOLVE) begin
            o.status = ST_MISS;
            for (int i = 0; i < route_count; i++) begin
                if (routes[i].lbl != r.in_label)
                    continue;
                if (!r.in_if_any && (routes[i].any || routes[i].iface != r.in_interface))
                    continue;
                o.status = ST_OK;
                o.found_out_interface = routes[i].oif;
                o.found_op_count = routes[i].cnt;
                o.found_op0_code = routes[i].c0;
                o.found_op0_label = routes[i].l0;
                o.found_op1_code = routes[i].c1;
                o.found_op1_label = routes[i].l1;
                break;
            end
            return o;
        end
        if (r.operation == OPER_REMOVE) begin
            idx = find_label(r.in_label);
            if (idx < 0) begin
                o.status = ST_MISS;
                return o;
            end
            for (int i = idx; i + 1 < route_count; i++)
                routes[i] = routes[i + 1];
            route_count--;
            o.status = ST_OK;
            return o;
        end
        if (r.operation != OPER_INSTALL) begin
            o.status = ST_BAD;
            return o;
        end
        cnt = (r.op_count > 2) ? 2'd2 : r.op_count;
        e = '0;
        e.any = r.in_if_any;
        e.iface = r.in_if_any ? 8'd0 : r.in_interface;
        e.oif = r.out_interface;
        e.cnt = cnt;
        if (cnt >= 1) begin
            if (r.op0_code == LOP_BAD) begin
                o.status = ST_BAD;
                return o;
            end
            e.c0 = r.op0_code;
            e.l0 = (r.op0_code == LOP_POP) ? '0 : r.op0_label;
        end
        if (cnt >= 2) begin
            if (r.op1_code == LOP_BAD) begin
                o.status = ST_BAD;
                return o;
            end
            e.c1 = r.op1_code;
            e.l1 = (r.op1_code == LOP_POP) ? '0 : r.op1_label;
        end
        if (r.allocate_new) begin
            if (route_count >= DEPTH) begin
                o.status = ST_FULL;
                return o;
            end
            if (last_label >= LAST_LABEL) begin
                o.status = ST_EXHAUSTED;
                return o;
            end
            last_label++;
            e.lbl = last_label;
            routes[route_count] = e;
            route_count++;
            o.label = last_label;
            o.status = ST_OK;
            return o;
        end
        idx = find_label(r.in_label);
        if (idx < 0) begin
            o.status = ST_MISS;
            return o;
        end
        e.lbl = r.in_label;
        routes[idx] = e;
        o.status = ST_OK;
        return o;
    endfunction

    function automatic req_t random_req();
        req_t r;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        r = raw[$bits(req_t)-1:0];
        r.operation = ($urandom_range(0, 99) < 2) ? OPER_BAD : 2'($urandom_range(0, 2));
        // Aim mostly at labels that may be live so lookups hit.
        if ($urandom_range(0, 9) < 8)
            r.in_label = last_label - 20'($urandom_range(0, 40));
        r.allocate_new = ($urandom_range(0, 1) == 1);
        r.in_interface = 8'($urandom_range(0, 3)) | ($urandom_range(0, 9) == 0 ? 8'hFC : 8'h0);
        r.in_if_any = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) != 0) begin
            if (r.op0_code == LOP_BAD) r.op0_code = LOP_SWAP;
            if (r.op1_code == LOP_BAD) r.op1_code = LOP_PUSH;
        end
        return r;
    endfunction

    function automatic req_t mk(logic [1:0] oper, logic [LABEL_W-1:0] lbl, bit alloc,
                                bit any, logic [7:0] ifc);
        req_t r;
        r = '0;
        r.operation = oper;
        r.in_label = lbl;
        r.allocate_new = alloc;
        r.in_if_any = any;
        r.in_interface = ifc;
        r.out_interface = 8'hFF;
        r.op_count = 2'd2;
        r.op0_code = LOP_PUSH;
        r.op0_label = 20'hFFFFF;
        r.op1_code = LOP_SWAP;
        r.op1_label = 20'hABCDE;
        return r;
    endfunction

    // Driver: advance one transfer per accepted edge.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            push <= 1'b0;
            request <= '0;
        end else begin
            if (push && !full) begin
                expected_resps.insert(expected_resps.size(), apply_request(request));
                void'(pending_reqs.pop_front());
            end
            if (pending_reqs.size() > 0 && !hold_push
                && $urandom_range(0, 99) >= idle_pct) begin
                push <= 1'b1;
                request <= pending_reqs[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: compare each popped response with the oldest prediction.
    always @(posedge clk or negedge rst_n) begin
        resp_t x;
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_resps.size() == 0) begin
                    $error("unexpected response %p", response);
                    fail_count++;
                end else begin
                    x = expected_resps.pop_front();
                    if (x.status != response.status) begin
                        $error("status exp %0d got %0d", x.status, response.status);
                        fail_count++;
                    end
                    if (x.label != response.label) begin
                        $error("label exp %0h got %0h", x.label, response.label);
                        fail_count++;
                    end
                    if (x.found_out_interface != response.found_out_interface) begin
                        $error("found_out_interface exp %0h got %0h",
                               x.found_out_interface, response.found_out_interface);
                        fail_count++;
                    end
                    if (x.found_op_count != response.found_op_count) begin
                        $error("found_op_count exp %0d got %0d",
                               x.found_op_count, response.found_op_count);
                        fail_count++;
                    end
                    if (x.found_op0_code != response.found_op0_code) begin
                        $error("found_op0_code exp %0d got %0d",
                               x.found_op0_code, response.found_op0_code);
                        fail_count++;
                    end
                    if (x.found_op0_label != response.found_op0_label) begin
                        $error("found_op0_label exp %0h got %0h",
                               x.found_op0_label, response.found_op0_label);
                        fail_count++;
                    end
                    if (x.found_op1_code != response.found_op1_code) begin
                        $error("found_op1_code exp %0d got %0d",
                               x.found_op1_code, response.found_op1_code);
                        fail_count++;
                    end
                    if (x.found_op1_label != response.found_op1_label) begin
                        $error("found_op1_label exp %0h got %0h",
                               x.found_op1_label, response.found_op1_label);
                        fail_count++;
                    end
                end
            end
            pop <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #10000000;
        $display("** mpls_label_forwarding_table: FAILED **");
        $finish;
    end

    initial begin
        req_t r;
        rst_n = 1'b0;
        idle_pct = 20;
        hold_push = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: misses on empty table, allocations, lookups, edge cases.
        add_req(mk(OPER_RESOLVE, 20'd16, 0, 1, 8'd0));
        add_req(mk(OPER_REMOVE, 20'hFFFFF, 0, 0, 8'd0));
        add_req(mk(OPER_INSTALL, 20'd16, 0, 0, 8'd0));
        add_req(mk(OPER_INSTALL, 20'd0, 1, 0, 8'hFF));
        add_req(mk(OPER_INSTALL, 20'd0, 1, 1, 8'h55));
        add_req(mk(OPER_RESOLVE, 20'd16, 0, 0, 8'hFF));
        add_req(mk(OPER_RESOLVE, 20'd16, 0, 0, 8'h00));
        add_req(mk(OPER_RESOLVE, 20'd17, 0, 0, 8'h55));
        add_req(mk(OPER_RESOLVE, 20'd17, 0, 1, 8'h00));
        r = mk(OPER_INSTALL, 20'd16, 0, 0, 8'h0A);
        r.op_count = 2'd3; r.op0_code = LOP_POP; r.op1_code = LOP_POP;
        add_req(r);
        add_req(mk(OPER_RESOLVE, 20'd16, 0, 1, 8'h00));
        r = mk(OPER_INSTALL, 20'd17, 0, 1, 8'h00);
        r.op_count = 2'd1; r.op0_code = LOP_SWAP;
        add_req(r);
        add_req(mk(OPER_RESOLVE, 20'd17, 0, 1, 8'h00));
        r = mk(OPER_INSTALL, 20'd0, 1, 0, 8'd1);
        r.op_count = 2'd2; r.op1_code = LOP_BAD;
        add_req(r);
        r.op_count = 2'd1;
        add_req(r);
        r.op_count = 2'd0; r.op0_code = LOP_BAD;
        add_req(r);
        r = mk(OPER_BAD, 20'd16, 0, 0, 8'd0);
        add_req(r);
        add_req(mk(OPER_REMOVE, 20'd16, 0, 0, 8'd0));
        add_req(mk(OPER_RESOLVE, 20'd17, 0, 1, 8'd0));
        // Fill past the table size to reach the full status.
        for (int i = 0; i < 66; i++)
            add_req(mk(OPER_INSTALL, 20'd0, 1, i[0], 8'(i)));
        add_req(mk(OPER_REMOVE, 20'd50, 0, 0, 8'd0));
        add_req(mk(OPER_RESOLVE, 20'd51, 0, 1, 8'd0));

        // Pause until the block has drained.
        wait (pending_reqs.size() == 0);
        hold_push = 1'b1;
        wait (expected_resps.size() == 0);
        @(posedge clk);
        hold_push = 1'b0;

        // Random traffic, with a stretch of no idling in the middle.
        for (int n = 0; n < 1000; n++) begin
            if (pending_reqs.size() > 20)
                wait (pending_reqs.size() < 10);
            idle_pct = (n >= 400 && n < 600) ? 0 : 20;
            add_req(random_req());
        end
        wait (pending_reqs.size() == 0);
        idle_pct = 20;
        wait (expected_resps.size() == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && expected_resps.size() == 0)
            $display("** mpls_label_forwarding_table: PASSED **");
        else
            $display("** mpls_label_forwarding_table: FAILED **");
        $finish;
    end
endmodule
